// ===== sv/oate_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oate_pkg: shared types for the ordered array table engine
// Request codes, status codes, datapath micro-operations, controller states
// and the status bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package oate_pkg;

    typedef enum logic [3:0] {
        RT_INSERT       = 4'd0,
        RT_REMOVE_AT    = 4'd1,
        RT_REMOVE_VALUE = 4'd2,
        RT_POP_FRONT    = 4'd3,
        RT_POP_BACK     = 4'd4,
        RT_FIRST_INDEX  = 4'd5,
        RT_LAST_INDEX   = 4'd6,
        RT_REVERSE      = 4'd7,
        RT_SORT_UP      = 4'd8,
        RT_SORT_DOWN    = 4'd9,
        RT_READ         = 4'd10
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_ST_RANGE,
        UOP_ST_EMPTY,
        UOP_ST_FULL,
        UOP_INS_INIT,
        UOP_INS_RD,
        UOP_INS_WR,
        UOP_INS_PUT,
        UOP_SHD_INIT,
        UOP_SHD_RD,
        UOP_SHD_WR,
        UOP_SHD_END,
        UOP_POPB,
        UOP_FWD_INIT,
        UOP_FWD_RD,
        UOP_FWD_CHK,
        UOP_CMP_INIT,
        UOP_CMP_RD,
        UOP_CMP_WR,
        UOP_CMP_END,
        UOP_BWD_INIT,
        UOP_BWD_RD,
        UOP_BWD_CHK,
        UOP_REV_INIT,
        UOP_REV_RDA,
        UOP_REV_RDB,
        UOP_REV_WRA,
        UOP_REV_WRB,
        UOP_SRT_INIT,
        UOP_SRT_KRD,
        UOP_SRT_KEY,
        UOP_SRT_PRD,
        UOP_SRT_PCHK,
        UOP_SRT_PUT,
        UOP_RD_RD,
        UOP_RD_GET
    } t_uop;

    typedef enum logic [5:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_INS_LOOP,
        CS_INS_RD,
        CS_INS_WR,
        CS_SHD_LOOP,
        CS_SHD_RD,
        CS_SHD_WR,
        CS_FWD_LOOP,
        CS_FWD_RD,
        CS_FWD_CHK,
        CS_CMP_LOOP,
        CS_CMP_RD,
        CS_CMP_WR,
        CS_BWD_LOOP,
        CS_BWD_RD,
        CS_BWD_CHK,
        CS_REV_LOOP,
        CS_REV_RDA,
        CS_REV_RDB,
        CS_REV_WRA,
        CS_REV_WRB,
        CS_SRT_LOOP,
        CS_SRT_KRD,
        CS_SRT_KEY,
        CS_SRT_INNER,
        CS_SRT_PRD,
        CS_SRT_PCHK,
        CS_SRT_PUT,
        CS_RD_RD,
        CS_RD_GET,
        CS_OUT
    } t_ctl_state;

    typedef struct packed {
        t_req_type req;
        logic      every;
        logic      pos_gt_cnt;
        logic      pos_ge_cnt;
        logic      cnt_zero;
        logic      cnt_full;
        logic      i_gt_pos;
        logic      i_p1_lt_cnt;
        logic      i_lt_cnt;
        logic      i_nz;
        logic      i_lt_half;
        logic      j_nz;
        logic      match;
        logic      move;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/oate_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oate_req_if: request channel of the ordered array table engine
// Valid/ready handshake carrying one request.
// ----------------------------------------------------------------------------
interface oate_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic [6:0]         position_in;
    logic signed [31:0] item_value;
    logic               remove_every;

    modport source (output valid, req_type, position_in, item_value, remove_every,
                    input ready);
    modport sink   (input valid, req_type, position_in, item_value, remove_every,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/oate_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oate_rsp_if: result channel of the ordered array table engine
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface oate_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [5:0]         found_position;
    logic [6:0]         removed_count;
    logic [6:0]         size_now;

    modport source (output valid, status, read_value, found, found_position,
                    removed_count, size_now, input ready);
    modport sink   (input valid, status, read_value, found, found_position,
                    removed_count, size_now, output ready);
endinterface
`default_nettype wire

// ===== sv/oate_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oate_datapath: element memory, loop indices and result registers
// Executes one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module oate_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire oate_pkg::t_uop     i_uop,
    input  wire logic [3:0]         i_req_type,
    input  wire logic [6:0]         i_position_in,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic               i_remove_every,
    output oate_pkg::t_dp_stat      o_stat,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic                    o_found,
    output logic [5:0]              o_found_position,
    output logic [6:0]              o_removed_count,
    output logic [6:0]              o_size_now
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = (CW > 7) ? CW : 7;

    logic [31:0]         r_mem [DEPTH];
    logic [31:0]         r_rdata;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_w, n_w;
    logic [31:0]         r_key, n_key;
    logic [31:0]         r_tmp, n_tmp;
    logic [31:0]         r_val, n_val;
    logic [6:0]          r_pos, n_pos;
    logic                r_every, n_every;
    oate_pkg::t_req_type r_req, n_req;
    oate_pkg::t_status   r_status, n_status;
    logic [31:0]         r_rd, n_rd;
    logic                r_found, n_found;
    logic [CW-1:0]       r_fpos, n_fpos;
    logic [CW-1:0]       r_removed, n_removed;

    logic [PW-1:0]       w_pos_ext;
    logic [PW-1:0]       w_cnt_ext;
    logic [CW-1:0]       w_k;
    logic                w_desc;
    logic [CW-1:0]       w_rd_idx;
    logic                w_we;
    logic [CW-1:0]       w_wr_idx;
    logic [31:0]         w_wdata;

    assign w_pos_ext = PW'(r_pos);
    assign w_cnt_ext = PW'(r_count);
    assign w_k       = r_count - CW'(1) - r_i;
    assign w_desc    = (r_req == oate_pkg::RT_SORT_DOWN);

    always_comb begin
        o_stat.req         = r_req;
        o_stat.every       = r_every;
        o_stat.pos_gt_cnt  = w_pos_ext > w_cnt_ext;
        o_stat.pos_ge_cnt  = w_pos_ext >= w_cnt_ext;
        o_stat.cnt_zero    = r_count == '0;
        o_stat.cnt_full    = r_count >= CW'(DEPTH);
        o_stat.i_gt_pos    = PW'(r_i) > w_pos_ext;
        o_stat.i_p1_lt_cnt = ({1'b0, r_i} + (CW+1)'(1)) < {1'b0, r_count};
        o_stat.i_lt_cnt    = r_i < r_count;
        o_stat.i_nz        = r_i != '0;
        o_stat.i_lt_half   = r_i < (r_count >> 1);
        o_stat.j_nz        = r_j != '0;
        o_stat.match       = r_rdata == r_val;
        o_stat.move        = w_desc ? ($signed(r_rdata) < $signed(r_key))
                                    : ($signed(r_key) < $signed(r_rdata));
    end

    // Read address, write port and register updates per micro-operation.
    always_comb begin
        w_rd_idx  = r_i;
        w_we      = 1'b0;
        w_wr_idx  = r_i;
        w_wdata   = r_rdata;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_w       = r_w;
        n_key     = r_key;
        n_tmp     = r_tmp;
        n_val     = r_val;
        n_pos     = r_pos;
        n_every   = r_every;
        n_req     = r_req;
        n_status  = r_status;
        n_rd      = r_rd;
        n_found   = r_found;
        n_fpos    = r_fpos;
        n_removed = r_removed;
        unique case (i_uop) inside
            oate_pkg::UOP_LOAD: begin
                n_req     = oate_pkg::t_req_type'(i_req_type);
                n_pos     = i_position_in;
                n_val     = i_item_value;
                n_every   = i_remove_every;
                n_status  = oate_pkg::ST_OK;
                n_rd      = '0;
                n_found   = 1'b0;
                n_fpos    = '0;
                n_removed = '0;
            end
            oate_pkg::UOP_ST_RANGE: n_status = oate_pkg::ST_RANGE;
            oate_pkg::UOP_ST_EMPTY: n_status = oate_pkg::ST_EMPTY;
            oate_pkg::UOP_ST_FULL:  n_status = oate_pkg::ST_FULL;
            oate_pkg::UOP_INS_INIT: n_i = r_count;
            oate_pkg::UOP_INS_RD:   w_rd_idx = r_i - CW'(1);
            oate_pkg::UOP_INS_WR: begin
                w_we = 1'b1;
                n_i  = r_i - CW'(1);
            end
            oate_pkg::UOP_INS_PUT: begin
                w_we     = 1'b1;
                w_wr_idx = CW'(w_pos_ext);
                w_wdata  = r_val;
                n_count  = r_count + CW'(1);
            end
            oate_pkg::UOP_SHD_INIT:
                n_i = (r_req == oate_pkg::RT_POP_FRONT) ? '0 : CW'(w_pos_ext);
            oate_pkg::UOP_SHD_RD: w_rd_idx = r_i + CW'(1);
            oate_pkg::UOP_SHD_WR: begin
                w_we = 1'b1;
                n_i  = r_i + CW'(1);
            end
            oate_pkg::UOP_SHD_END, oate_pkg::UOP_POPB: begin
                n_count   = r_count - CW'(1);
                n_removed = CW'(1);
            end
            oate_pkg::UOP_FWD_INIT: n_i = '0;
            oate_pkg::UOP_FWD_RD:   w_rd_idx = r_i;
            oate_pkg::UOP_FWD_CHK: begin
                if (r_rdata == r_val) begin
                    if (r_req != oate_pkg::RT_REMOVE_VALUE) begin
                        n_found = 1'b1;
                        n_fpos  = r_i;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            oate_pkg::UOP_CMP_INIT: begin
                n_i = '0;
                n_w = '0;
            end
            oate_pkg::UOP_CMP_RD: w_rd_idx = r_i;
            oate_pkg::UOP_CMP_WR: begin
                n_i = r_i + CW'(1);
                if (r_rdata != r_val) begin
                    w_we     = 1'b1;
                    w_wr_idx = r_w;
                    n_w      = r_w + CW'(1);
                end
            end
            oate_pkg::UOP_CMP_END: begin
                n_removed = r_count - r_w;
                n_count   = r_w;
            end
            oate_pkg::UOP_BWD_INIT: n_i = r_count;
            oate_pkg::UOP_BWD_RD:   w_rd_idx = r_i - CW'(1);
            oate_pkg::UOP_BWD_CHK: begin
                if (r_rdata == r_val) begin
                    n_found = 1'b1;
                    n_fpos  = r_i - CW'(1);
                end else begin
                    n_i = r_i - CW'(1);
                end
            end
            oate_pkg::UOP_REV_INIT: n_i = '0;
            oate_pkg::UOP_REV_RDA:  w_rd_idx = r_i;
            oate_pkg::UOP_REV_RDB: begin
                w_rd_idx = w_k;
                n_tmp    = r_rdata;
            end
            oate_pkg::UOP_REV_WRA: w_we = 1'b1;
            oate_pkg::UOP_REV_WRB: begin
                w_we     = 1'b1;
                w_wr_idx = w_k;
                w_wdata  = r_tmp;
                n_i      = r_i + CW'(1);
            end
            oate_pkg::UOP_SRT_INIT: n_i = CW'(1);
            oate_pkg::UOP_SRT_KRD:  w_rd_idx = r_i;
            oate_pkg::UOP_SRT_KEY: begin
                n_key = r_rdata;
                n_j   = r_i;
            end
            oate_pkg::UOP_SRT_PRD: w_rd_idx = r_j - CW'(1);
            oate_pkg::UOP_SRT_PCHK: begin
                if (o_stat.move) begin
                    w_we     = 1'b1;
                    w_wr_idx = r_j;
                    n_j      = r_j - CW'(1);
                end
            end
            oate_pkg::UOP_SRT_PUT: begin
                w_we     = 1'b1;
                w_wr_idx = r_j;
                w_wdata  = r_key;
                n_i      = r_i + CW'(1);
            end
            oate_pkg::UOP_RD_RD:  w_rd_idx = CW'(w_pos_ext);
            oate_pkg::UOP_RD_GET: n_rd = r_rdata;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx[AW-1:0]] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_req   <= oate_pkg::RT_INSERT;
        end else begin
            r_count <= n_count;
            r_req   <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_w       <= n_w;
        r_key     <= n_key;
        r_tmp     <= n_tmp;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_every   <= n_every;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_found   <= n_found;
        r_fpos    <= n_fpos;
        r_removed <= n_removed;
    end

    assign o_status         = r_status;
    assign o_read_value     = r_rd;
    assign o_found          = r_found;
    assign o_found_position = 6'(r_fpos);
    assign o_removed_count  = 7'(r_removed);
    assign o_size_now       = 7'(r_count);

endmodule
`default_nettype wire

// ===== sv/oate_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oate_controller: request sequencer of the ordered array table engine
// Walks each request through its loop of datapath micro-operations.
// ----------------------------------------------------------------------------
module oate_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    output logic                    o_rsp_valid,
    input  wire logic               i_rsp_ready,
    input  wire oate_pkg::t_dp_stat i_stat,
    output oate_pkg::t_uop          o_uop
);
    oate_pkg::t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oate_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_uop       = oate_pkg::UOP_NONE;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        unique case (r_state)
            oate_pkg::CS_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_uop   = oate_pkg::UOP_LOAD;
                    n_state = oate_pkg::CS_DISPATCH;
                end
            end
            oate_pkg::CS_DISPATCH: begin
                n_state = oate_pkg::CS_OUT;
                unique case (i_stat.req) inside
                    oate_pkg::RT_INSERT: begin
                        if (i_stat.pos_gt_cnt) begin
                            o_uop = oate_pkg::UOP_ST_RANGE;
                        end else if (i_stat.cnt_full) begin
                            o_uop = oate_pkg::UOP_ST_FULL;
                        end else begin
                            o_uop   = oate_pkg::UOP_INS_INIT;
                            n_state = oate_pkg::CS_INS_LOOP;
                        end
                    end
                    oate_pkg::RT_REMOVE_AT: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_uop = oate_pkg::UOP_ST_RANGE;
                        end else begin
                            o_uop   = oate_pkg::UOP_SHD_INIT;
                            n_state = oate_pkg::CS_SHD_LOOP;
                        end
                    end
                    oate_pkg::RT_REMOVE_VALUE: begin
                        if (i_stat.every) begin
                            o_uop   = oate_pkg::UOP_CMP_INIT;
                            n_state = oate_pkg::CS_CMP_LOOP;
                        end else begin
                            o_uop   = oate_pkg::UOP_FWD_INIT;
                            n_state = oate_pkg::CS_FWD_LOOP;
                        end
                    end
                    oate_pkg::RT_POP_FRONT: begin
                        if (i_stat.cnt_zero) begin
                            o_uop = oate_pkg::UOP_ST_EMPTY;
                        end else begin
                            o_uop   = oate_pkg::UOP_SHD_INIT;
                            n_state = oate_pkg::CS_SHD_LOOP;
                        end
                    end
                    oate_pkg::RT_POP_BACK: begin
                        o_uop = i_stat.cnt_zero ? oate_pkg::UOP_ST_EMPTY
                                                : oate_pkg::UOP_POPB;
                    end
                    oate_pkg::RT_FIRST_INDEX: begin
                        o_uop   = oate_pkg::UOP_FWD_INIT;
                        n_state = oate_pkg::CS_FWD_LOOP;
                    end
                    oate_pkg::RT_LAST_INDEX: begin
                        o_uop   = oate_pkg::UOP_BWD_INIT;
                        n_state = oate_pkg::CS_BWD_LOOP;
                    end
                    oate_pkg::RT_REVERSE: begin
                        o_uop   = oate_pkg::UOP_REV_INIT;
                        n_state = oate_pkg::CS_REV_LOOP;
                    end
                    oate_pkg::RT_SORT_UP, oate_pkg::RT_SORT_DOWN: begin
                        o_uop   = oate_pkg::UOP_SRT_INIT;
                        n_state = oate_pkg::CS_SRT_LOOP;
                    end
                    oate_pkg::RT_READ: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_uop = oate_pkg::UOP_ST_RANGE;
                        end else begin
                            n_state = oate_pkg::CS_RD_RD;
                        end
                    end
                    default: ;
                endcase
            end
            oate_pkg::CS_INS_LOOP: begin
                if (i_stat.i_gt_pos) begin
                    n_state = oate_pkg::CS_INS_RD;
                end else begin
                    o_uop   = oate_pkg::UOP_INS_PUT;
                    n_state = oate_pkg::CS_OUT;
                end
            end
            oate_pkg::CS_INS_RD: begin
                o_uop   = oate_pkg::UOP_INS_RD;
                n_state = oate_pkg::CS_INS_WR;
            end
            oate_pkg::CS_INS_WR: begin
                o_uop   = oate_pkg::UOP_INS_WR;
                n_state = oate_pkg::CS_INS_LOOP;
            end
            oate_pkg::CS_SHD_LOOP: begin
                if (i_stat.i_p1_lt_cnt) begin
                    n_state = oate_pkg::CS_SHD_RD;
                end else begin
                    o_uop   = oate_pkg::UOP_SHD_END;
                    n_state = oate_pkg::CS_OUT;
                end
            end
            oate_pkg::CS_SHD_RD: begin
                o_uop   = oate_pkg::UOP_SHD_RD;
                n_state = oate_pkg::CS_SHD_WR;
            end
            oate_pkg::CS_SHD_WR: begin
                o_uop   = oate_pkg::UOP_SHD_WR;
                n_state = oate_pkg::CS_SHD_LOOP;
            end
            oate_pkg::CS_FWD_LOOP: begin
                n_state = i_stat.i_lt_cnt ? oate_pkg::CS_FWD_RD : oate_pkg::CS_OUT;
            end
            oate_pkg::CS_FWD_RD: begin
                o_uop   = oate_pkg::UOP_FWD_RD;
                n_state = oate_pkg::CS_FWD_CHK;
            end
            oate_pkg::CS_FWD_CHK: begin
                o_uop = oate_pkg::UOP_FWD_CHK;
                if (!i_stat.match) begin
                    n_state = oate_pkg::CS_FWD_LOOP;
                end else if (i_stat.req == oate_pkg::RT_REMOVE_VALUE) begin
                    n_state = oate_pkg::CS_SHD_LOOP;
                end else begin
                    n_state = oate_pkg::CS_OUT;
                end
            end
            oate_pkg::CS_CMP_LOOP: begin
                if (i_stat.i_lt_cnt) begin
                    n_state = oate_pkg::CS_CMP_RD;
                end else begin
                    o_uop   = oate_pkg::UOP_CMP_END;
                    n_state = oate_pkg::CS_OUT;
                end
            end
            oate_pkg::CS_CMP_RD: begin
                o_uop   = oate_pkg::UOP_CMP_RD;
                n_state = oate_pkg::CS_CMP_WR;
            end
            oate_pkg::CS_CMP_WR: begin
                o_uop   = oate_pkg::UOP_CMP_WR;
                n_state = oate_pkg::CS_CMP_LOOP;
            end
            oate_pkg::CS_BWD_LOOP: begin
                n_state = i_stat.i_nz ? oate_pkg::CS_BWD_RD : oate_pkg::CS_OUT;
            end
            oate_pkg::CS_BWD_RD: begin
                o_uop   = oate_pkg::UOP_BWD_RD;
                n_state = oate_pkg::CS_BWD_CHK;
            end
            oate_pkg::CS_BWD_CHK: begin
                o_uop   = oate_pkg::UOP_BWD_CHK;
                n_state = i_stat.match ? oate_pkg::CS_OUT : oate_pkg::CS_BWD_LOOP;
            end
            oate_pkg::CS_REV_LOOP: begin
                n_state = i_stat.i_lt_half ? oate_pkg::CS_REV_RDA : oate_pkg::CS_OUT;
            end
            oate_pkg::CS_REV_RDA: begin
                o_uop   = oate_pkg::UOP_REV_RDA;
                n_state = oate_pkg::CS_REV_RDB;
            end
            oate_pkg::CS_REV_RDB: begin
                o_uop   = oate_pkg::UOP_REV_RDB;
                n_state = oate_pkg::CS_REV_WRA;
            end
            oate_pkg::CS_REV_WRA: begin
                o_uop   = oate_pkg::UOP_REV_WRA;
                n_state = oate_pkg::CS_REV_WRB;
            end
            oate_pkg::CS_REV_WRB: begin
                o_uop   = oate_pkg::UOP_REV_WRB;
                n_state = oate_pkg::CS_REV_LOOP;
            end
            oate_pkg::CS_SRT_LOOP: begin
                n_state = i_stat.i_lt_cnt ? oate_pkg::CS_SRT_KRD : oate_pkg::CS_OUT;
            end
            oate_pkg::CS_SRT_KRD: begin
                o_uop   = oate_pkg::UOP_SRT_KRD;
                n_state = oate_pkg::CS_SRT_KEY;
            end
            oate_pkg::CS_SRT_KEY: begin
                o_uop   = oate_pkg::UOP_SRT_KEY;
                n_state = oate_pkg::CS_SRT_INNER;
            end
            oate_pkg::CS_SRT_INNER: begin
                n_state = i_stat.j_nz ? oate_pkg::CS_SRT_PRD : oate_pkg::CS_SRT_PUT;
            end
            oate_pkg::CS_SRT_PRD: begin
                o_uop   = oate_pkg::UOP_SRT_PRD;
                n_state = oate_pkg::CS_SRT_PCHK;
            end
            oate_pkg::CS_SRT_PCHK: begin
                o_uop   = oate_pkg::UOP_SRT_PCHK;
                n_state = i_stat.move ? oate_pkg::CS_SRT_INNER : oate_pkg::CS_SRT_PUT;
            end
            oate_pkg::CS_SRT_PUT: begin
                o_uop   = oate_pkg::UOP_SRT_PUT;
                n_state = oate_pkg::CS_SRT_LOOP;
            end
            oate_pkg::CS_RD_RD: begin
                o_uop   = oate_pkg::UOP_RD_RD;
                n_state = oate_pkg::CS_RD_GET;
            end
            oate_pkg::CS_RD_GET: begin
                o_uop   = oate_pkg::UOP_RD_GET;
                n_state = oate_pkg::CS_OUT;
            end
            oate_pkg::CS_OUT: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = oate_pkg::CS_IDLE;
                end
            end
            default: n_state = oate_pkg::CS_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/ordered_array_table_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_table_engine: packed array of signed words with list operations
// Insert, remove, search, reverse, sort and read on a fixed-capacity array,
// one result per request.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake   | Payload
//  ---------+-----------+-------------+-------------------------------------------
//  i_req    | in        | valid/ready | req_type, position_in, item_value,
//           |           |             | remove_every
//  o_rsp    | out       | valid/ready | status, read_value, found, found_position,
//           |           |             | removed_count, size_now
//
// One request is handled at a time. The loops of each request step through
// the element memory with one read and one write per cycle and registered
// read data. The sort is an insertion sort over that memory, which has one
// read port and one write port. Reset clears the element count and the
// controller; the memory itself is not cleared, as only entries below the
// count are read.
// The result is held until the consumer takes it, and no new request is
// accepted before that.
// ----------------------------------------------------------------------------
module ordered_array_table_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oate_req_if.sink   i_req,
    oate_rsp_if.source o_rsp
);
    oate_pkg::t_uop     w_uop;
    oate_pkg::t_dp_stat w_stat;

    // The controller sequences each request as a string of micro-operations.
    oate_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_uop       (w_uop)
    );

    // The datapath holds the elements, the count, the loop indices and the
    // result fields, which stay stable while the result waits.
    oate_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_uop            (w_uop),
        .i_req_type       (i_req.req_type),
        .i_position_in    (i_req.position_in),
        .i_item_value     (i_req.item_value),
        .i_remove_every   (i_req.remove_every),
        .o_stat           (w_stat),
        .o_status         (o_rsp.status),
        .o_read_value     (o_rsp.read_value),
        .o_found          (o_rsp.found),
        .o_found_position (o_rsp.found_position),
        .o_removed_count  (o_rsp.removed_count),
        .o_size_now       (o_rsp.size_now)
    );

`ifndef SYNTHESIS
    // A request is never taken while a result is still on offer.
    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request accepted while a result is pending");

    // A failed request removes nothing.
    a_fail_no_remove : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != oate_pkg::ST_OK) |-> o_rsp.removed_count == 7'd0)
        else $error("elements removed by a failed request");

    // A reported match lies inside the array.
    a_found_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> {1'b0, o_rsp.found_position} < o_rsp.size_now)
        else $error("match position beyond the element count");

    // Without a match the position reads as zero.
    a_no_match_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> o_rsp.found_position == 6'd0)
        else $error("position reported without a match");
`endif

endmodule
`default_nettype wire

// ===== test/ordered_array_table_engine_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Array list scoreboard
// Mirrors the element array and count, predicts the result of every accepted
// request and compares returned results against the queue of predictions.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [5:0]         found_position;
    logic [6:0]         removed_count;
    logic [6:0]         size_now;
} t_list_result;

class list_scoreboard;
    logic signed [31:0] elems[64];
    int                 count;
    t_list_result       pending[$];
    int                 mismatches;

    function new();
        count      = 0;
        mismatches = 0;
    endfunction

    function void drop_at(int p);
        for (int i = p; i + 1 < count; i++) elems[i] = elems[i + 1];
        count--;
    endfunction

    function void sort_elems(bit descending);
        logic signed [31:0] key;
        int                 j;
        for (int i = 1; i < count; i++) begin
            key = elems[i];
            j   = i;
            while (j > 0 && (descending ? elems[j-1] < key : key < elems[j-1])) begin
                elems[j] = elems[j-1];
                j--;
            end
            elems[j] = key;
        end
    endfunction

    // Applies one accepted request to the mirror and queues its result.
    function void note_request(logic [3:0] kind, int p, logic signed [31:0] v, bit every);
        t_list_result r;
        logic signed [31:0] t;
        int                 w;
        r = '0;
        case (kind)
            oate_pkg::RT_INSERT: begin
                if (p > count) r.status = oate_pkg::ST_RANGE;
                else if (count >= 64) r.status = oate_pkg::ST_FULL;
                else begin
                    for (int i = count; i > p; i--) elems[i] = elems[i-1];
                    elems[p] = v;
                    count++;
                end
            end
            oate_pkg::RT_REMOVE_AT: begin
                if (p >= count) r.status = oate_pkg::ST_RANGE;
                else begin
                    drop_at(p);
                    r.removed_count = 7'd1;
                end
            end
            oate_pkg::RT_REMOVE_VALUE: begin
                if (every) begin
                    w = 0;
                    for (int i = 0; i < count; i++)
                        if (elems[i] != v) begin
                            elems[w] = elems[i];
                            w++;
                        end
                    r.removed_count = 7'(count - w);
                    count = w;
                end else begin
                    for (int i = 0; i < count; i++)
                        if (elems[i] == v) begin
                            drop_at(i);
                            r.removed_count = 7'd1;
                            break;
                        end
                end
            end
            oate_pkg::RT_POP_FRONT, oate_pkg::RT_POP_BACK: begin
                if (count == 0) r.status = oate_pkg::ST_EMPTY;
                else begin
                    if (kind == oate_pkg::RT_POP_FRONT) drop_at(0);
                    else count--;
                    r.removed_count = 7'd1;
                end
            end
            oate_pkg::RT_FIRST_INDEX: begin
                for (int i = 0; i < count; i++)
                    if (elems[i] == v) begin
                        r.found = 1'b1;
                        r.found_position = 6'(i);
                        break;
                    end
            end
            oate_pkg::RT_LAST_INDEX: begin
                for (int i = count - 1; i >= 0; i--)
                    if (elems[i] == v) begin
                        r.found = 1'b1;
                        r.found_position = 6'(i);
                        break;
                    end
            end
            oate_pkg::RT_REVERSE: begin
                for (int i = 0; i < count / 2; i++) begin
                    t = elems[i];
                    elems[i] = elems[count-1-i];
                    elems[count-1-i] = t;
                end
            end
            oate_pkg::RT_SORT_UP:   sort_elems(1'b0);
            oate_pkg::RT_SORT_DOWN: sort_elems(1'b1);
            oate_pkg::RT_READ: begin
                if (p >= count) r.status = oate_pkg::ST_RANGE;
                else r.read_value = elems[p];
            end
            default: ;
        endcase
        r.size_now = 7'(count);
        pending = {pending, r};
    endfunction

    function void check_result(t_list_result got);
        t_list_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

// ===== test/ordered_array_table_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Array list engine testbench
// Drives directed and random requests with random gaps on both channels and
// checks each result against a behavioural mirror of the array.
// ----------------------------------------------------------------------------
module ordered_array_table_engine_test;

    localparam int         WATCHDOG_LIMIT = 50000;
    localparam logic [3:0] REQ_RESERVED   = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_cycles = 0;

    oate_req_if req_ch ();
    oate_rsp_if rsp_ch ();

    list_scoreboard board = new();

    ordered_array_table_engine #(.DEPTH(64)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // A gap length: usually nothing or a few cycles, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Values drawn from a small pool so that searches and removals hit often,
    // with the extremes and fully random words mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 7) - 4;
        endcase
    endfunction

    // Presents one request and holds it until the engine takes it.
    task automatic send_request(logic [3:0] kind, logic [6:0] p, logic [31:0] v, bit every);
        @(negedge i_clk);
        repeat (gap_length()) @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.position_in  <= p;
        req_ch.item_value   <= v;
        req_ch.remove_every <= every;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(kind, p, v, every);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // Random request weighted towards keeping the array part full.
    task automatic send_random();
        int         roll;
        logic [3:0] kind;
        logic [6:0] p;
        roll = $urandom_range(0, 99);
        if (roll < 30) kind = oate_pkg::RT_INSERT;
        else if (roll < 97) kind = 4'($urandom_range(1, 10));
        else kind = 4'($urandom_range(11, 15));
        if ($urandom_range(0, 9) == 0) p = 7'($urandom);
        else p = 7'($urandom_range(0, board.count + 1));
        send_request(kind, p, pick_value(), 1'($urandom_range(0, 1)));
    endtask

    // Result side: random back-pressure, sample at the rising edge.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result({rsp_ch.status, rsp_ch.read_value, rsp_ch.found,
                                rsp_ch.found_position, rsp_ch.removed_count,
                                rsp_ch.size_now});
    end

    // Watchdog over cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.position_in  = '0;
        req_ch.item_value   = '0;
        req_ch.remove_every = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-array cases, extremes, every request kind.
        send_request(oate_pkg::RT_POP_FRONT, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_POP_BACK, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_READ, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_REMOVE_AT, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_REMOVE_VALUE, 7'd0, 32'd5, 1'b1);
        send_request(oate_pkg::RT_INSERT, 7'd1, 32'd5, 1'b0);
        send_request(oate_pkg::RT_INSERT, 7'd0, 32'h7fff_ffff, 1'b0);
        send_request(oate_pkg::RT_INSERT, 7'd1, 32'h8000_0000, 1'b1);
        send_request(oate_pkg::RT_INSERT, 7'd0, 32'hffff_ffff, 1'b0);
        send_request(oate_pkg::RT_INSERT, 7'd3, 32'h7fff_ffff, 1'b0);
        send_request(oate_pkg::RT_INSERT, 7'h7f, 32'd0, 1'b0);
        send_request(oate_pkg::RT_FIRST_INDEX, 7'd0, 32'h7fff_ffff, 1'b0);
        send_request(oate_pkg::RT_LAST_INDEX, 7'd0, 32'h7fff_ffff, 1'b0);
        send_request(oate_pkg::RT_FIRST_INDEX, 7'd0, 32'd12345, 1'b0);
        send_request(oate_pkg::RT_SORT_UP, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_READ, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_SORT_DOWN, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_REVERSE, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_READ, 7'd3, 32'd0, 1'b0);
        send_request(oate_pkg::RT_READ, 7'd4, 32'd0, 1'b0);
        send_request(REQ_RESERVED, 7'h55, 32'h5555_5555, 1'b1);
        send_request(oate_pkg::RT_REMOVE_VALUE, 7'd0, 32'h7fff_ffff, 1'b0);
        send_request(oate_pkg::RT_REMOVE_AT, 7'd1, 32'd0, 1'b0);
        // Fill to capacity, then try one more insert.
        while (board.count < 64)
            send_request(oate_pkg::RT_INSERT, 7'(board.count), pick_value(), 1'b0);
        send_request(oate_pkg::RT_INSERT, 7'd64, 32'd1, 1'b0);
        send_request(oate_pkg::RT_SORT_UP, 7'd0, 32'd0, 1'b0);
        send_request(oate_pkg::RT_READ, 7'd63, 32'd0, 1'b0);
        send_request(oate_pkg::RT_LAST_INDEX, 7'd0, board.elems[63], 1'b0);

        // Let the engine drain completely before carrying on.
        wait (board.pending.size() == 0);

        for (int n = 0; n < 1000; n++) begin
            send_random();
            // Occasionally empty the array by popping from the back.
            if ($urandom_range(0, 99) == 0)
                while (board.count > 0)
                    send_request(oate_pkg::RT_POP_BACK, 7'd0, 32'd0, 1'b0);
        end

        wait (board.pending.size() == 0);
        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
sv/oate_pkg.sv
sv/oate_req_if.sv
sv/oate_rsp_if.sv
sv/oate_datapath.sv
sv/oate_controller.sv
sv/ordered_array_table_engine.sv
test/ordered_array_table_engine_scoreboard.sv
test/ordered_array_table_engine_test.sv
